// ===== hdl/min_product_path_counter_top_assert.svh =====
// Assertion macros for the minimum product path counter top level.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef MIN_PRODUCT_PATH_COUNTER_TOP_ASSERT_SVH
`define MIN_PRODUCT_PATH_COUNTER_TOP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define MPC_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define MPC_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mpc_pkg.sv =====
// Shared types, codes and constants for the minimum product path counter.
// No dependencies.
package mpc_pkg;

  localparam int NODE_W        = 10;
  localparam int CNT_W         = 17;
  localparam int COST_BITS     = 16;
  localparam int LOG_FRAC_BITS = 24;
  localparam int IP_W          = $clog2(COST_BITS);
  localparam int W_BITS        = IP_W + LOG_FRAC_BITS;
  localparam int DIST_W        = 40;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 10;
  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 8192;

  localparam logic [CNT_W-1:0] COUNT_MOD = 17'd104659;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIE_TOL    = 8'd1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADNODE = 2'd2,
    ST_ZERO    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                 command;
    logic [NODE_W-1:0]    end_a;
    logic [NODE_W-1:0]    end_b;
    logic [COST_BITS-1:0] cost;
    logic [NODE_W-1:0]    query_node;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  path_count;
    logic              reached;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] dist_sum;
    logic [CNT_W-1:0]  count;
    logic              queued;
  } node_rec_t;

  typedef struct packed {
    logic [DIST_W-1:0] key;
    logic [NODE_W-1:0] node;
  } heap_rec_t;

  typedef struct packed {
    logic [NODE_W-1:0] target;
    logic [W_BITS-1:0] weight;
  } ent_rec_t;

endpackage

// ===== hdl/mpc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module mpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mpc_log2.sv =====
// Iterative fixed-point base-2 logarithm: normalize one bit a cycle, then one
// squaring per fraction bit. Depends on mpc_pkg.
module mpc_log2
  import mpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [COST_BITS-1:0] cost,
  output logic                 done,
  output logic [W_BITS-1:0]    weight
);

  localparam int CNT_BW = $clog2(LOG_FRAC_BITS);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQR  = 3'b100
  } lstate_t;

  lstate_t                  state;
  logic [31:0]              m;
  logic [IP_W-1:0]          ip;
  logic [LOG_FRAC_BITS-1:0] frac;
  logic [CNT_BW-1:0]        bit_cnt;
  logic [63:0]              sq;
  logic [32:0]              sq_top;

  assign sq     = m * m;
  assign sq_top = sq[63:31];
  assign weight = {ip, frac};

  always_ff @(posedge clk) begin
    done <= !rst && (state == L_SQR) && (bit_cnt == '0);
    if (rst) begin
      state <= L_IDLE;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            m     <= 32'(cost) << (32 - COST_BITS);
            ip    <= IP_W'(COST_BITS - 1);
            frac  <= '0;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (m[31]) begin
            bit_cnt <= CNT_BW'(LOG_FRAC_BITS - 1);
            state   <= L_SQR;
          end else begin
            m  <= m << 1;
            ip <= ip - 1'b1;
          end
        end
        L_SQR: begin
          // square, then renormalize and shift in one fraction bit
          if (sq_top[32]) begin
            m <= sq_top[32:1];
          end else begin
            m <= sq_top[31:0];
          end
          frac <= {frac[LOG_FRAC_BITS-2:0], sq_top[32]};
          if (bit_cnt == '0) begin
            state <= L_IDLE;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/min_product_path_counter_top.sv =====
// Minimum product path counter: edge store, log unit and search sequencer.
// Depends on mpc_pkg, mpc_ram, mpc_log2 and the assertion header.
//
// Usage: send command words on req (valid/ready). Each accepted word gives
// exactly one rsp word. Load edge converts the cost to a log2 weight and
// appends both directions to per-node adjacency lists; run search does a
// priority search from node 1 counting minimum product paths mod 104659;
// query returns a node's count and reached flag; clear graph empties the
// edge lists. Registers are written on the cfg channel (index 0 node_count,
// index 1 tie_tolerance); the user must write them only while the block is
// idle, as the block itself does not enforce this. cfg_ready is always high.
// Per word: load runs the log unit (normalize, then LOG_FRAC_BITS squarings),
// then updates the list of each direction; clear graph sweeps all MAX_NODES
// list heads; run sweeps all MAX_NODES node records, then repeatedly pops
// the best heap entry, found by a linear scan, and visits its adjacency list.
// Reset: a sweep over MAX_NODES entries clears list heads and node records;
// req_ready stays low meanwhile. A finished rsp word is held in an output
// register while the receiver stalls; a new req word is taken meanwhile, and
// its result waits until the register frees.
module min_product_path_counter_top
  import mpc_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NA_W   = $clog2(MAX_NODES);
  localparam int HS_W   = $clog2(MAX_NODES + 1);
  localparam int SLOTS  = 2 * MAX_EDGES;
  localparam int EA_W   = $clog2(SLOTS);
  localparam int SLOT_W = EA_W + 1;
  localparam int ET_W   = $clog2(MAX_EDGES + 1);
  localparam int LIM    = MAX_NODES - 1;
  localparam logic [SLOT_W-1:0] EMPTY = SLOT_W'(SLOTS);

  typedef enum logic [17:0] {
    S_INIT      = 18'd1,
    S_IDLE      = 18'd2,
    S_DECODE    = 18'd4,
    S_LOG       = 18'd8,
    S_APP_RD    = 18'd16,
    S_APP_WR    = 18'd32,
    S_APP_LINK  = 18'd64,
    S_CLRG      = 18'd128,
    S_RCLR      = 18'd256,
    S_LOOP      = 18'd512,
    S_SCAN      = 18'd1024,
    S_POP_RD    = 18'd2048,
    S_POP_WR    = 18'd4096,
    S_EDGE      = 18'd8192,
    S_EDGE_WAIT = 18'd16384,
    S_RELAX     = 18'd32768,
    S_QWAIT     = 18'd65536,
    S_OUT       = 18'd131072
  } state_t;

  state_t            state;
  logic [NODE_W-1:0] node_count;
  logic [7:0]        tie_tol;
  req_t              req_r;
  rsp_t              res;
  logic [ET_W-1:0]   edge_total;
  logic [HS_W-1:0]   heap_size;
  logic [NA_W-1:0]   clr_idx;
  logic              side;
  logic [W_BITS-1:0] w_r;
  logic [SLOT_W-1:0] tail_r;
  logic [SLOT_W-1:0] e_r;
  logic [NODE_W-1:0] y_r;
  logic [DIST_W-1:0] dx;
  logic [DIST_W-1:0] cand;
  logic [CNT_W-1:0]  par_count;
  heap_rec_t         best;
  logic [NA_W-1:0]   best_idx;
  logic [HS_W-1:0]   scan_idx;
  logic              pend_v;
  logic [NA_W-1:0]   pend_idx;

  // RAM ports
  logic                hl_we;
  logic [NA_W-1:0]     hl_wa, hl_ra;
  logic [2*SLOT_W-1:0] hl_wd, hl_rd;
  logic                node_we;
  logic [NA_W-1:0]     node_wa, node_ra;
  node_rec_t           node_wd, node_rd;
  logic                heap_we;
  logic [NA_W-1:0]     heap_wa, heap_ra;
  heap_rec_t           heap_wd, heap_rd;
  logic                ent_we;
  logic [EA_W-1:0]     ent_wa, ent_ra;
  ent_rec_t            ent_wd, ent_rd;
  logic                link_we;
  logic [EA_W-1:0]     link_wa, link_ra;
  logic [SLOT_W-1:0]   link_wd, link_rd;

  logic                log_start, log_done;
  logic [W_BITS-1:0]   log_weight;

  logic [NODE_W-1:0]   n_lim;
  logic                load_bad_node, load_ok, query_bad;
  logic                clr_last;
  logic [NODE_W-1:0]   app_from, app_to;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   hl_head, hl_tail;
  logic                improve, tie, push;
  logic [DIST_W-1:0]   diff;
  logic [CNT_W:0]      sum_raw;
  logic [CNT_W-1:0]    sum;
  logic                better, target_bad;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign n_lim = (32'(node_count) < 32'(LIM)) ? node_count : NODE_W'(LIM);
  assign load_bad_node = (req_r.end_a == '0) || (req_r.end_a > n_lim) ||
                         (req_r.end_b == '0) || (req_r.end_b > n_lim);
  assign load_ok   = !load_bad_node && (req_r.cost != '0) &&
                     (edge_total < ET_W'(MAX_EDGES));
  assign query_bad = (req_r.query_node == '0) || (req_r.query_node > n_lim);
  assign log_start = (state == S_DECODE) && (req_r.command == CMD_LOAD) && load_ok;
  assign clr_last  = (clr_idx == NA_W'(MAX_NODES - 1));

  assign app_from = side ? req_r.end_b : req_r.end_a;
  assign app_to   = side ? req_r.end_a : req_r.end_b;
  assign slot     = (SLOT_W'(edge_total) << 1) | SLOT_W'(side);
  assign hl_head  = hl_rd[2*SLOT_W-1:SLOT_W];
  assign hl_tail  = hl_rd[SLOT_W-1:0];

  // relaxation against the neighbor record just read
  assign diff    = (node_rd.dist_sum >= cand) ? (node_rd.dist_sum - cand)
                                              : (cand - node_rd.dist_sum);
  assign improve = !node_rd.valid ||
                   ((node_rd.dist_sum > cand) && (diff > DIST_W'(tie_tol)));
  assign tie     = !improve && (diff <= DIST_W'(tie_tol));
  assign push    = improve && !node_rd.queued && (heap_size < HS_W'(MAX_NODES));
  assign sum_raw = {1'b0, node_rd.count} + {1'b0, par_count};
  assign sum     = (sum_raw >= {1'b0, COUNT_MOD}) ? CNT_W'(sum_raw - {1'b0, COUNT_MOD})
                                                 : sum_raw[CNT_W-1:0];

  // smaller key wins; on equal keys the larger node number wins
  assign better = (heap_rd.key < best.key) ||
                  ((heap_rd.key == best.key) && (heap_rd.node > best.node));
  assign target_bad = (ent_rd.target == '0) || (ent_rd.target > n_lim);

  always_comb begin
    hl_we   = 1'b0;
    hl_wa   = clr_idx;
    hl_wd   = {EMPTY, EMPTY};
    hl_ra   = '0;
    node_we = 1'b0;
    node_wa = clr_idx;
    node_wd = '0;
    node_ra = '0;
    heap_we = 1'b0;
    heap_wa = '0;
    heap_wd = '0;
    heap_ra = '0;
    ent_we  = 1'b0;
    ent_wa  = slot[EA_W-1:0];
    ent_wd  = '{target: app_to, weight: w_r};
    ent_ra  = e_r[EA_W-1:0];
    link_we = 1'b0;
    link_wa = slot[EA_W-1:0];
    link_wd = EMPTY;
    link_ra = e_r[EA_W-1:0];
    case (state)
      S_INIT: begin
        hl_we   = 1'b1;
        node_we = 1'b1;
      end
      S_CLRG: begin
        hl_we = 1'b1;
      end
      S_DECODE: begin
        node_ra = NA_W'(req_r.query_node);
      end
      S_APP_RD: begin
        hl_ra = NA_W'(app_from);
      end
      S_APP_WR: begin
        ent_we  = 1'b1;
        link_we = 1'b1;
        hl_we   = 1'b1;
        hl_wa   = NA_W'(app_from);
        hl_wd   = (hl_head == EMPTY) ? {slot, slot} : {hl_head, slot};
      end
      S_APP_LINK: begin
        link_we = 1'b1;
        link_wa = tail_r[EA_W-1:0];
        link_wd = slot;
      end
      S_RCLR: begin
        node_we = 1'b1;
        if ((clr_idx == NA_W'(1)) && (n_lim != '0)) begin
          node_wd = '{valid: 1'b1, dist_sum: '0, count: CNT_W'(1), queued: 1'b1};
        end
        heap_we = clr_last && (n_lim != '0);
        heap_wd = '{key: '0, node: NODE_W'(1)};
      end
      S_SCAN: begin
        heap_ra = scan_idx[NA_W-1:0];
      end
      S_POP_RD: begin
        heap_ra = NA_W'(heap_size - 1'b1);
        node_ra = NA_W'(best.node);
        hl_ra   = NA_W'(best.node);
      end
      S_POP_WR: begin
        // move the last heap entry into the popped slot, drop the queued mark
        heap_we = 1'b1;
        heap_wa = best_idx;
        heap_wd = heap_rd;
        node_we = 1'b1;
        node_wa = NA_W'(best.node);
        node_wd = node_rd;
        node_wd.queued = 1'b0;
      end
      S_EDGE_WAIT: begin
        node_ra = NA_W'(ent_rd.target);
      end
      S_RELAX: begin
        node_wa = NA_W'(y_r);
        if (improve) begin
          node_we = 1'b1;
          node_wd = '{valid: 1'b1, dist_sum: cand, count: par_count,
                      queued: node_rd.queued | push};
          heap_we = push;
          heap_wa = heap_size[NA_W-1:0];
          heap_wd = '{key: cand, node: y_r};
        end else if (tie) begin
          node_we = 1'b1;
          node_wd = node_rd;
          node_wd.count = sum;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      node_count <= NODE_W'(2);
      tie_tol    <= 8'd1;
      edge_total <= '0;
      heap_size  <= '0;
      clr_idx    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_NODE_COUNT: node_count <= cfg_data[NODE_W-1:0];
          REG_TIE_TOL:    tie_tol    <= cfg_data[7:0];
          default: ;
        endcase
      end
      // drop the word once taken, unless the output state refills it now
      if (rsp_valid && rsp_ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            req_r <= req;
            res   <= '0;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          clr_idx <= '0;
          case (req_r.command)
            CMD_LOAD: begin
              if (load_bad_node) begin
                res.status <= ST_BADNODE;
                state      <= S_OUT;
              end else if (req_r.cost == '0) begin
                res.status <= ST_ZERO;
                state      <= S_OUT;
              end else if (!load_ok) begin
                res.status <= ST_FULL;
                state      <= S_OUT;
              end else begin
                state <= S_LOG;
              end
            end
            CMD_RUN:   state <= S_RCLR;
            CMD_QUERY: begin
              if (query_bad) begin
                res.status <= ST_BADNODE;
                state      <= S_OUT;
              end else begin
                state <= S_QWAIT;
              end
            end
            CMD_CLEAR: state <= S_CLRG;
            default:   state <= S_OUT;
          endcase
        end
        S_LOG: begin
          if (log_done) begin
            w_r   <= log_weight;
            side  <= 1'b0;
            state <= S_APP_RD;
          end
        end
        S_APP_RD: state <= S_APP_WR;
        S_APP_WR: begin
          tail_r <= hl_tail;
          if (hl_head != EMPTY) begin
            state <= S_APP_LINK;
          end else if (!side) begin
            side  <= 1'b1;
            state <= S_APP_RD;
          end else begin
            edge_total <= edge_total + 1'b1;
            state      <= S_OUT;
          end
        end
        S_APP_LINK: begin
          if (!side) begin
            side  <= 1'b1;
            state <= S_APP_RD;
          end else begin
            edge_total <= edge_total + 1'b1;
            state      <= S_OUT;
          end
        end
        S_CLRG: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_last) begin
            edge_total <= '0;
            state      <= S_OUT;
          end
        end
        S_RCLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_last) begin
            heap_size <= (n_lim != '0) ? HS_W'(1) : '0;
            state     <= S_LOOP;
          end
        end
        S_LOOP: begin
          scan_idx <= '0;
          pend_v   <= 1'b0;
          state    <= (heap_size == '0) ? S_OUT : S_SCAN;
        end
        S_SCAN: begin
          pend_v   <= (scan_idx < heap_size);
          pend_idx <= scan_idx[NA_W-1:0];
          if (scan_idx < heap_size) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (pend_v && ((pend_idx == '0) || better)) begin
            best     <= heap_rd;
            best_idx <= pend_idx;
          end
          if (!pend_v && (scan_idx == heap_size)) begin
            state <= S_POP_RD;
          end
        end
        S_POP_RD: state <= S_POP_WR;
        S_POP_WR: begin
          par_count <= node_rd.count;
          dx        <= best.key;
          e_r       <= hl_head;
          heap_size <= heap_size - 1'b1;
          state     <= S_EDGE;
        end
        S_EDGE: begin
          state <= (e_r == EMPTY) ? S_LOOP : S_EDGE_WAIT;
        end
        S_EDGE_WAIT: begin
          e_r <= link_rd;
          if (target_bad) begin
            state <= S_EDGE;
          end else begin
            y_r   <= ent_rd.target;
            cand  <= dx + DIST_W'(ent_rd.weight);
            state <= S_RELAX;
          end
        end
        S_RELAX: begin
          if (push) begin
            heap_size <= heap_size + 1'b1;
          end
          // a self loop tie doubles the parent's own count for later entries
          if (tie && (y_r == best.node)) begin
            par_count <= sum;
          end
          state <= S_EDGE;
        end
        S_QWAIT: begin
          res.path_count <= node_rd.count;
          res.reached    <= node_rd.valid;
          state          <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mpc_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .cost   (req_r.cost),
    .done   (log_done),
    .weight (log_weight)
  );

  mpc_ram #(.WIDTH(2 * SLOT_W), .DEPTH(MAX_NODES)) u_hl_ram (
    .clk(clk), .we(hl_we), .waddr(hl_wa), .wdata(hl_wd), .raddr(hl_ra), .rdata(hl_rd)
  );

  mpc_ram #(.WIDTH($bits(node_rec_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_wa), .wdata(node_wd), .raddr(node_ra),
    .rdata(node_rd)
  );

  mpc_ram #(.WIDTH($bits(heap_rec_t)), .DEPTH(MAX_NODES)) u_heap_ram (
    .clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd), .raddr(heap_ra),
    .rdata(heap_rd)
  );

  mpc_ram #(.WIDTH($bits(ent_rec_t)), .DEPTH(SLOTS)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(ent_ra), .rdata(ent_rd)
  );

  mpc_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd), .raddr(link_ra),
    .rdata(link_rd)
  );

`include "min_product_path_counter_top_assert.svh"

  `MPC_ASSERT_NOW(a_heap_bound, 1'b1, heap_size <= HS_W'(MAX_NODES), "heap overflow")
  `MPC_ASSERT_NOW(a_edge_bound, 1'b1, edge_total <= ET_W'(MAX_EDGES), "edge count overflow")
  `MPC_ASSERT_NOW(a_pop_nonempty, state == S_POP_WR, heap_size != '0, "pop from empty heap")
  `MPC_ASSERT_NEXT(a_rsp_source, !rsp_valid && (state != S_OUT), !rsp_valid,
                   "response word raised outside output state")

endmodule

// ===== dv/min_product_path_counter_checker.sv =====
// Checker for the minimum product path counter: watches req, rsp and cfg words,
// predicts each response and compares it field by field. Depends on mpc_pkg.
module min_product_path_counter_checker
  import mpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  req_t                  req,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  rsp_t                  rsp,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors
);

  localparam int NODES = DEF_MAX_NODES;
  localparam int EDGES = DEF_MAX_EDGES;
  localparam int SLOTS = 2 * EDGES;
  localparam int NIL   = SLOTS;
  localparam longint unsigned PATH_MOD = 64'd104659;

  int unsigned node_limit, tie_tol, edges_held, pq_len, mismatches;
  int unsigned adj_to [SLOTS];
  longint unsigned adj_w [SLOTS];
  int unsigned adj_next [SLOTS];
  int unsigned head [NODES];
  int unsigned tail [NODES];
  longint unsigned node_len [NODES];
  bit seen [NODES];
  int unsigned paths [NODES];
  bit in_queue [NODES];
  longint unsigned pq_key [NODES];
  int unsigned pq_node [NODES];
  rsp_t expected_rsp [$];

  initial errors = 0;

  // log2 of the cost, 24 fraction bits by repeated squaring, truncated
  function automatic longint unsigned log_weight(int unsigned c);
    int unsigned ip;
    longint unsigned m, frac;
    ip = 0;
    frac = 0;
    while (ip < 31 && (c >> (ip + 1)) != 0) ip++;
    m = 64'(c) << (31 - ip);
    for (int i = LOG_FRAC_BITS - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | (64'd1 << i);
      end
    end
    return (64'(ip) << LOG_FRAC_BITS) | frac;
  endfunction

  function automatic void empty_lists();
    for (int i = 0; i < NODES; i++) begin
      head[i] = NIL;
      tail[i] = NIL;
    end
    edges_held = 0;
  endfunction

  function automatic void wipe_nodes();
    for (int i = 0; i < NODES; i++) begin
      node_len[i] = 0;
      seen[i] = 0;
      paths[i] = 0;
      in_queue[i] = 0;
    end
    pq_len = 0;
  endfunction

  function automatic void link(int unsigned slot, int unsigned from, int unsigned to,
                               longint unsigned w);
    adj_to[slot] = to;
    adj_w[slot] = w;
    adj_next[slot] = NIL;
    if (head[from] == NIL) head[from] = slot;
    else adj_next[tail[from]] = slot;
    tail[from] = slot;
  endfunction

  function automatic void enqueue(int unsigned v, longint unsigned key);
    if (pq_len < NODES) begin
      pq_key[pq_len] = key;
      pq_node[pq_len] = v;
      pq_len++;
      in_queue[v] = 1;
    end
  endfunction

  // Search from node 1; pops use the key they were pushed with
  function automatic void search(int unsigned n);
    int unsigned best, x, e, y;
    longint unsigned dx, cand, diff;
    wipe_nodes();
    if (n < 1) return;
    seen[1] = 1;
    paths[1] = 1;
    enqueue(1, 0);
    while (pq_len > 0) begin
      best = 0;
      for (int i = 1; i < pq_len; i++)
        if (pq_key[i] < pq_key[best] ||
            (pq_key[i] == pq_key[best] && pq_node[i] > pq_node[best]))
          best = i;
      dx = pq_key[best];
      x = pq_node[best];
      pq_len--;
      pq_key[best] = pq_key[pq_len];
      pq_node[best] = pq_node[pq_len];
      in_queue[x] = 0;
      e = head[x];
      while (e < NIL) begin
        y = adj_to[e];
        if (y >= 1 && y <= n) begin
          cand = dx + adj_w[e];
          if (!seen[y] || (node_len[y] > cand && node_len[y] - cand > tie_tol)) begin
            seen[y] = 1;
            node_len[y] = cand;
            paths[y] = paths[x];
            if (!in_queue[y]) enqueue(y, cand);
          end else begin
            diff = node_len[y] >= cand ? node_len[y] - cand : cand - node_len[y];
            if (diff <= tie_tol) paths[y] = (64'(paths[y]) + paths[x]) % PATH_MOD;
          end
        end
        e = adj_next[e];
      end
    end
  endfunction

  function automatic rsp_t predict_rsp(req_t w);
    rsp_t r;
    int unsigned n, a, b, q;
    longint unsigned wt;
    r = '0;
    r.status = ST_OK;
    n = node_limit < NODES - 1 ? node_limit : NODES - 1;
    a = w.end_a;
    b = w.end_b;
    q = w.query_node;
    case (w.command)
      CMD_LOAD: begin
        if (a < 1 || a > n || b < 1 || b > n) r.status = ST_BADNODE;
        else if (w.cost == 0) r.status = ST_ZERO;
        else if (edges_held >= EDGES) r.status = ST_FULL;
        else begin
          wt = log_weight(w.cost);
          link(2 * edges_held, a, b, wt);
          link(2 * edges_held + 1, b, a, wt);
          edges_held++;
        end
      end
      CMD_RUN: search(n);
      CMD_QUERY: begin
        if (q < 1 || q > n) r.status = ST_BADNODE;
        else begin
          r.path_count = paths[q][CNT_W-1:0];
          r.reached = seen[q];
        end
      end
      default: empty_lists();
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      node_limit = 2;
      tie_tol = 1;
      empty_lists();
      wipe_nodes();
      expected_rsp.delete();
      mismatches = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected rsp word: status %0d count %0d reached %0d",
                     rsp.status, rsp.path_count, rsp.reached);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status || rsp.path_count !== want.path_count ||
              rsp.reached !== want.reached) begin
            mismatches++;
            if (mismatches <= 10)
              $display("rsp mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                       want.status, want.path_count, want.reached,
                       rsp.status, rsp.path_count, rsp.reached);
          end
        end
      end
      if (req_valid && req_ready) expected_rsp = {expected_rsp, predict_rsp(req)};
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NODE_COUNT) node_limit = cfg_data & 10'h3FF;
        else if (cfg_index == REG_TIE_TOL) tie_tol = cfg_data[7:0];
      end
    end
    errors <= mismatches + expected_rsp.size();
  end

endmodule

// ===== dv/min_product_path_counter_top_tb.sv =====
// Testbench top for the minimum product path counter: clock, reset, stimulus
// and verdict. Depends on mpc_pkg, the block and min_product_path_counter_checker.
module min_product_path_counter_top_tb;
  import mpc_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b1;
  rsp_t                  rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int unsigned           words_out = 0;
  int unsigned           words_back = 0;
  int unsigned           stall_left = 0;
  bit                    calm = 1'b0;
  int unsigned           items;

  always #6 clk = ~clk;

  min_product_path_counter_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  min_product_path_counter_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors)
  );

  // Count words in flight so config writes wait for an idle block
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) words_out <= words_out + 1;
      if (rsp_valid && rsp_ready) words_back <= words_back + 1;
    end
  end

  // Receiver: stall in random bursts; no new burst starts while calm
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #60000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Send one word; unused fields carry random noise. Valid stays high after
  // acceptance so back-to-back words never drop it within a step.
  task automatic send_word(input cmd_t cmd, input logic [9:0] a, input logic [9:0] b,
                           input logic [15:0] c, input logic [9:0] q);
    req_t w;
    int unsigned gap;
    w = req_t'($bits(req_t)'({$urandom, $urandom}));
    w.command = cmd;
    if (cmd == CMD_LOAD) begin
      w.end_a = a;
      w.end_b = b;
      w.cost = c;
    end else if (cmd == CMD_QUERY) begin
      w.query_node = q;
    end
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    @(posedge clk);
    items++;
  endtask

  // Drop valid and hold until every response is back
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(negedge clk);
    while (words_out != words_back) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    wait_idle();
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly a node in use; now and then any 10-bit value
  function automatic logic [9:0] pick_node(int unsigned nc);
    if (nc >= 1 && $urandom_range(0, 15) != 0) return 10'($urandom_range(1, nc));
    return 10'($urandom);
  endfunction

  // Small costs make equal products (and near ties in the log) common
  function automatic logic [15:0] pick_cost();
    int unsigned r;
    r = $urandom_range(0, 29);
    if (r == 0) return 16'd0;
    if (r < 5) return 16'($urandom);
    case ($urandom_range(0, 9))
      0: return 16'd1;
      1: return 16'd2;
      2: return 16'd3;
      3: return 16'd4;
      4: return 16'd6;
      5: return 16'd8;
      6: return 16'd9;
      7: return 16'd12;
      8: return 16'd16;
      default: return 16'd24;
    endcase
  endfunction

  initial begin
    int unsigned nc, tt, k, nq;
    items = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: queries before any run, bad endpoints and zero cost,
    // extreme costs, a self loop, then clear keeping search results
    send_word(CMD_QUERY, 0, 0, 0, 10'd1);
    send_word(CMD_QUERY, 0, 0, 0, 10'd0);
    send_word(CMD_LOAD, 10'd0, 10'd1, 16'd5, 0);
    send_word(CMD_LOAD, 10'd1, 10'd3, 16'd5, 0);
    send_word(CMD_LOAD, 10'd1023, 10'd1, 16'd0, 0);
    send_word(CMD_LOAD, 10'd1, 10'd2, 16'd0, 0);
    send_word(CMD_LOAD, 10'd1, 10'd2, 16'd1, 0);
    send_word(CMD_LOAD, 10'd1, 10'd2, 16'hFFFF, 0);
    send_word(CMD_LOAD, 10'd2, 10'd2, 16'd3, 0);
    send_word(CMD_LOAD, 10'd2, 10'd1, 16'd1, 0);
    send_word(CMD_RUN, 0, 0, 0, 0);
    send_word(CMD_QUERY, 0, 0, 0, 10'd2);
    send_word(CMD_QUERY, 0, 0, 0, 10'd3);
    send_word(CMD_CLEAR, 0, 0, 0, 0);
    send_word(CMD_QUERY, 0, 0, 0, 10'd2);
    send_word(CMD_RUN, 0, 0, 0, 0);
    send_word(CMD_QUERY, 0, 0, 0, 10'd2);
    // Masked tolerance, an unknown register, zero node count
    cfg_write(REG_TIE_TOL, 10'h3FF);
    cfg_write(8'd2, 10'h155);
    cfg_write(REG_NODE_COUNT, 10'd0);
    send_word(CMD_RUN, 0, 0, 0, 0);
    send_word(CMD_QUERY, 0, 0, 0, 10'd1);
    // Largest node, then shrink the node count under stored edges
    cfg_write(REG_NODE_COUNT, 10'd1023);
    send_word(CMD_LOAD, 10'd1023, 10'd1, 16'hFFFF, 0);
    send_word(CMD_LOAD, 10'd1, 10'd2, 16'd7, 0);
    send_word(CMD_RUN, 0, 0, 0, 0);
    send_word(CMD_QUERY, 0, 0, 0, 10'd1023);
    cfg_write(REG_NODE_COUNT, 10'd3);
    send_word(CMD_RUN, 0, 0, 0, 0);
    send_word(CMD_QUERY, 0, 0, 0, 10'd2);

    // Random phases: configure, build a graph, run, query
    while (items < 1650) begin
      calm <= (items > 1450) || ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: nc = 1023;
        1: nc = $urandom_range(0, 2);
        default: nc = $urandom_range(3, 24);
      endcase
      case ($urandom_range(0, 4))
        0: tt = 0;
        1: tt = 1;
        2: tt = 255;
        default: tt = $urandom_range(0, 1023);
      endcase
      if ($urandom_range(0, 7) == 0) cfg_write(8'($urandom_range(2, 255)), 10'($urandom));
      cfg_write(REG_NODE_COUNT, 10'(nc));
      cfg_write(REG_TIE_TOL, 10'(tt));
      if ($urandom_range(0, 2) == 0) send_word(CMD_CLEAR, 0, 0, 0, 0);
      k = $urandom_range(0, (3 * nc > 40) ? 40 : 3 * nc + 2);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_word(cmd_t'($urandom_range(0, 3)), 10'($urandom), 10'($urandom),
                    16'($urandom), 10'($urandom));
        else
          send_word(CMD_LOAD, pick_node(nc), pick_node(nc), pick_cost(), 0);
      end
      send_word(CMD_RUN, 0, 0, 0, 0);
      nq = $urandom_range(2, 8);
      for (int i = 0; i < nq; i++) send_word(CMD_QUERY, 0, 0, 0, pick_node(nc + 1));
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mpc_pkg.sv
hdl/mpc_ram.sv
hdl/mpc_log2.sv
hdl/min_product_path_counter_top.sv
dv/min_product_path_counter_checker.sv
dv/min_product_path_counter_top_tb.sv
